FILE: hw/rtl/tlbsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbsc_pkg
// Shared types and constants of the second-chance translation buffer.
// ----------------------------------------------------------------------------
package tlbsc_pkg;

	// field widths of the request and response
	localparam int unsigned PAGE_BITS   = 8;
	localparam int unsigned FRAME_BITS  = 8;
	localparam int unsigned ACTION_BITS = 2;

	// default number of entries
	localparam int unsigned ENTRIES_DEF = 16;

	// action codes; the fourth code is unused and leaves the state alone
	typedef enum logic [ACTION_BITS-1:0] {
		ACT_LOOKUP     = 2'd0,
		ACT_ADD        = 2'd1,
		ACT_INVALIDATE = 2'd2
	} action_e;

	// request payload
	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [PAGE_BITS-1:0]   page;
		logic [FRAME_BITS-1:0]  frame;
		logic                   write_access;
		logic                   dirty_in;
	} tlb_req_t;

	// response payload
	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] frame_out;
	} tlb_rsp_t;

	// one word of the entry memory
	typedef struct packed {
		logic [PAGE_BITS-1:0]  page;
		logic [FRAME_BITS-1:0] frame;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_SWEEP,
		ST_FILL,
		ST_DONE
	} state_e;

	// status from the sequencer to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_stat_t;

endpackage : tlbsc_pkg
`default_nettype wire

FILE: hw/rtl/tlbsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbsc_ram
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbsc_ram #(
	parameter int unsigned DEPTH = tlbsc_pkg::ENTRIES_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output tlbsc_pkg::entry_t     rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire tlbsc_pkg::entry_t wr_data
);
	import tlbsc_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : tlbsc_ram
`default_nettype wire

FILE: hw/rtl/tlbsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbsc_ctrl
// Sequencer: scans the entry memory for lookup and invalidate, finds a free
// or second-chance victim for add, and holds the valid, used and dirty bits.
// ----------------------------------------------------------------------------
module tlbsc_ctrl #(
	parameter int unsigned ENTRIES = tlbsc_pkg::ENTRIES_DEF,
	localparam int unsigned IW     = $clog2(ENTRIES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tlbsc_pkg::tlb_req_t req,
	input  wire logic              out_free,
	output tlbsc_pkg::ctrl_stat_t  stat,
	output tlbsc_pkg::tlb_rsp_t    rsp,
	output logic                   rd_en,
	output logic [IW-1:0]          rd_addr,
	input  wire tlbsc_pkg::entry_t rd_data,
	output logic                   wr_en,
	output logic [IW-1:0]          wr_addr,
	output tlbsc_pkg::entry_t      wr_data
);
	import tlbsc_pkg::*;

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	state_e            state_q, state_d;
	tlb_req_t          req_q;
	logic [IW-1:0]     idx_q;
	logic              issue_q;
	logic [IW-1:0]     hand_q;
	logic [IW-1:0]     victim_q;
	logic [ENTRIES-1:0] valid_q, used_q, dirty_q;
	logic              hit_q;
	logic [FRAME_BITS-1:0] fo_q;
	logic              vld_s1, last_s1;
	logic [IW-1:0]     idx_s1;
	logic              match_s1, scan_end, is_lookup;
	logic [IW-1:0]     hand_nxt;

	// compare stage on the registered read data
	assign is_lookup = (req_q.action == ACT_LOOKUP);
	assign match_s1  = vld_s1 && valid_q[idx_s1] && (rd_data.page == req_q.page);
	assign scan_end  = (state_q == ST_SCAN) && vld_s1 && (last_s1 || (match_s1 && is_lookup));
	assign hand_nxt  = (hand_q == LAST) ? '0 : hand_q + 1'b1;

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = victim_q;
		wr_data  = '{page: req_q.page, frame: req_q.frame};
		stat     = '{idle: 1'b0, done: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				stat.idle = 1'b1;
				if (start) begin
					unique case (req.action) inside
						ACT_LOOKUP, ACT_INVALIDATE: state_d = ST_SCAN;
						ACT_ADD:                    state_d = ST_FIND;
						default:                    state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = issue_q && !scan_end;
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_FIND: begin
				if (!valid_q[idx_q]) begin
					state_d = ST_FILL;
				end else if (idx_q == LAST) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (!used_q[hand_q]) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				stat.done = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp = '{hit: hit_q, frame_out: fo_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: scan pipeline, hand and entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			hand_q  <= '0;
			valid_q <= '0;
			used_q  <= '0;
			dirty_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					hit_q   <= 1'b0;
					issue_q <= start;
				end
				ST_SCAN: begin
					if (scan_end || (issue_q && idx_q == LAST)) begin
						issue_q <= 1'b0;
					end
					if (match_s1) begin
						if (is_lookup) begin
							hit_q          <= 1'b1;
							used_q[idx_s1] <= 1'b1;
							if (req_q.write_access) begin
								dirty_q[idx_s1] <= 1'b1;
							end
						end else begin
							valid_q[idx_s1] <= 1'b0;
							used_q[idx_s1]  <= 1'b0;
							dirty_q[idx_s1] <= 1'b0;
						end
					end
				end
				ST_SWEEP: begin
					// clear the mark of a used entry, stop at the first unused one
					if (used_q[hand_q]) begin
						used_q[hand_q] <= 1'b0;
					end
					hand_q <= hand_nxt;
				end
				ST_FILL: begin
					valid_q[victim_q] <= 1'b1;
					used_q[victim_q]  <= 1'b1;
					dirty_q[victim_q] <= req_q.dirty_in;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		last_s1 <= (idx_q == LAST);
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req;
				idx_q <= '0;
				fo_q  <= '0;
			end
			ST_SCAN: begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (match_s1 && is_lookup) begin
					fo_q <= rd_data.frame;
				end
			end
			ST_FIND: begin
				victim_q <= idx_q;
				idx_q    <= idx_q + 1'b1;
			end
			ST_SWEEP: begin
				victim_q <= hand_q;
			end
			default: ;
		endcase
	end

	// checks
	a_sweep_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> &valid_q)
		else $error("second-chance sweep while a free entry exists");

	a_fill_sets_flags: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(wr_addr)] && used_q[$past(wr_addr)])
		else $error("filled entry not marked valid and used");

	a_hit_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && rsp.hit |-> req_q.action == ACT_LOOKUP)
		else $error("hit reported for an action other than lookup");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle |-> !vld_s1 && !rd_en && !wr_en)
		else $error("memory access outstanding while idle");

endmodule : tlbsc_ctrl
`default_nettype wire

FILE: hw/rtl/tlb_second_chance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_second_chance
// Fully associative translation buffer with second-chance replacement.
// Lookup and invalidate raise rsp_valid after a one-entry-per-cycle scan of
// the read port that follows the request transfer.
// Add runs a free-entry search, then a sweep of up to ENTRIES+1 steps from
// the hand. One item at a time: the next request transfer follows only once
// the sequencer is through with the last, while the result may still wait.
// Reset clears valid, used and dirty bits and the hand at once; no clearing
// pass, memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module tlb_second_chance #(
	parameter int unsigned ENTRIES = tlbsc_pkg::ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire tlbsc_pkg::tlb_req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output tlbsc_pkg::tlb_rsp_t rsp
);
	import tlbsc_pkg::*;

	localparam int unsigned IW = $clog2(ENTRIES);

	ctrl_stat_t    stat;
	tlb_rsp_t      rsp_c;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	entry_t        rd_data, wr_data;
	logic          out_free;
	logic          rsp_valid_q;
	tlb_rsp_t      rsp_q;

	assign req_ready = stat.idle;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// entry memory
	tlbsc_ram #(.DEPTH(ENTRIES)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// sequencer
	tlbsc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && req_ready),
		.req      (req),
		.out_free (out_free),
		.stat     (stat),
		.rsp      (rsp_c),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= rsp_c;
		end
	end

endmodule : tlb_second_chance
`default_nettype wire
